// ----- sv/ale_pkg.sv -----
package ale_pkg;

   localparam logic [6:0] CAP_RESET = 7'd64;

   typedef enum logic [2:0] {
      MODE_CLEAR      = 3'd0,
      MODE_GET        = 3'd1,
      MODE_LOCATE     = 3'd2,
      MODE_INS_BEFORE = 3'd3,
      MODE_INS_AFTER  = 3'd4,
      MODE_APPEND     = 3'd5,
      MODE_DEL_VALUE  = 3'd6,
      MODE_DEL_POS    = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_BADPOS   = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   // what the sequencer has to do for one item
   typedef enum logic [2:0] {
      ACT_NONE     = 3'd0,
      ACT_CLEAR    = 3'd1,
      ACT_GET      = 3'd2,
      ACT_FIND_LOC = 3'd3,
      ACT_FIND_DEL = 3'd4,
      ACT_OPEN     = 3'd5,
      ACT_CLOSE    = 3'd6
   } act_type;

   typedef struct packed {
      status_type status;
      act_type    act;
   } plan_type;

endpackage

// ----- sv/ale_req_if.sv -----
interface ale_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         mode;
   logic [6:0]         position;
   logic signed [31:0] value;

   modport source (output valid, output mode, output position, output value, input ready);
   modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

// ----- sv/ale_rsp_if.sv -----
interface ale_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] read_value;
   logic [5:0]         found_index;
   logic [6:0]         count;

   modport source (output valid, output status, output read_value, output found_index,
                   output count, input ready);
   modport sink   (input valid, input status, input read_value, input found_index,
                   input count, output ready);
endinterface

// ----- sv/ale_plan.sv -----
module ale_plan #(
   parameter int DEPTH = 64,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  ale_pkg::mode_type mode,
   input  logic [6:0]        position,
   input  logic [CW-1:0]     count,
   input  logic [6:0]        capacity,
   output ale_pkg::plan_type plan,
   output logic [CW-1:0]     at
);
   import ale_pkg::*;

   localparam int XW = (CW > 7) ? CW : 7;

   logic [XW-1:0] cnt_x;
   logic [XW-1:0] pos_x;
   logic [XW-1:0] cap_x;
   logic [XW-1:0] at_x;
   logic          full;

   assign cnt_x = XW'(count);
   assign pos_x = XW'(position);
   assign cap_x = XW'(capacity);
   // limit is the smaller of capacity and the store depth
   assign full  = (cnt_x >= cap_x) || (cnt_x >= XW'(DEPTH));
   assign at    = at_x[CW-1:0];

   always_comb begin
      plan.status = ST_OK;
      plan.act    = ACT_NONE;
      at_x        = pos_x;
      case (mode)
         MODE_CLEAR: begin
            plan.act = ACT_CLEAR;
         end
         MODE_GET: begin
            if (pos_x < cnt_x) plan.act = ACT_GET;
            else plan.status = ST_BADPOS;
         end
         MODE_LOCATE: begin
            plan.act = ACT_FIND_LOC;
         end
         MODE_DEL_VALUE: begin
            plan.act = ACT_FIND_DEL;
         end
         MODE_INS_BEFORE: begin
            if (full) plan.status = ST_OVERFLOW;
            else if (pos_x > cnt_x) plan.status = ST_BADPOS;
            else plan.act = ACT_OPEN;
         end
         MODE_INS_AFTER: begin
            at_x = pos_x + 1'b1;
            if (full) plan.status = ST_OVERFLOW;
            else if (pos_x >= cnt_x) plan.status = ST_BADPOS;
            else plan.act = ACT_OPEN;
         end
         MODE_APPEND: begin
            at_x = cnt_x;
            if (full) plan.status = ST_OVERFLOW;
            else plan.act = ACT_OPEN;
         end
         MODE_DEL_POS: begin
            if (pos_x < cnt_x) plan.act = ACT_CLOSE;
            else plan.status = ST_BADPOS;
         end
         default: begin
            plan.act = ACT_NONE;
         end
      endcase
   end

endmodule

// ----- sv/array_list_engine_unit.sv -----
// Ordered list of signed words in a single-port-read, single-port-write store.
// req_ch carries mode, position and value; rsp_ch returns status, read_value,
// found_index and count, one result per item, valid/ready on both channels.
// csr_wr_en/csr_wr_data write the capacity limit (reset 64); write it only
// while no item is in flight.
// The block takes one item at a time: req_ch.ready is high only while idle.
// Steps from accept to the result in the output register: clear and
// rejected items go straight to the response step; get reads the entry,
// then responds; locate scans from index 0 until a hit or the end of the
// list; insert/append at slot a shifts the entries from a to count-1 up by
// one, then writes the value at a; delete at slot a shifts the entries
// above a down by one; delete by value scans for a hit, then deletes it.
// The block returns to idle after the load, ready for the next item.
// The store moves one entry per cycle: one read and one write port, with a
// registered read, so a shift streams read-then-write through one stage.
// Reset empties the list and sets capacity to 64; store contents are kept.
// A stalled receiver holds the result in the output register; the next item
// can be accepted meanwhile, and its result waits in the final step until
// the output register frees up.
module array_list_engine_unit #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   ale_req_if.sink          req_ch,
   ale_rsp_if.source        rsp_ch,
   input  logic             csr_wr_en,
   input  logic [6:0]       csr_wr_data
);
   import ale_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_GET   = 6'b000010,
      S_FIND  = 6'b000100,
      S_OPEN  = 6'b001000,
      S_CLOSE = 6'b010000,
      S_RESP  = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   logic [6:0]            capacity_ff;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [CW-1:0]         at_ff, at_in;
   logic [CW-1:0]         src_ff, src_in;
   logic [CW-1:0]         rem_ff, rem_in;
   logic [CW-1:0]         pend_addr_ff, pend_addr_in;
   logic                  pend_vld_ff, pend_vld_in;
   logic                  del_ff, del_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   status_type            res_status_ff, res_status_in;
   logic [31:0]           res_read_ff, res_read_in;
   logic [CW-1:0]         res_idx_ff, res_idx_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_load;
   status_type            rsp_status_ff;
   logic [31:0]           rsp_read_ff;
   logic [5:0]            rsp_index_ff;
   logic [6:0]            rsp_count_ff;

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic [AW-1:0]         rd_addr;
   logic [AW-1:0]         wr_addr;
   logic                  wr_en;
   logic [DATA_WIDTH-1:0] wr_data;

   plan_type              plan;
   logic [CW-1:0]         plan_at;
   logic                  accept;
   logic [63:0]           req_val64;
   logic [31:0]           pos32;
   logic [63:0]           rd64;
   logic [31:0]           idx32;
   logic [31:0]           cnt32;

   ale_plan #(.DEPTH(DEPTH)) u_plan (
      .mode     (mode_type'(req_ch.mode)),
      .position (req_ch.position),
      .count    (cnt_ff),
      .capacity (capacity_ff),
      .plan     (plan),
      .at       (plan_at)
   );

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_val64    = {{32{req_ch.value[31]}}, req_ch.value};
   assign pos32        = 32'(req_ch.position);
   assign rd64         = 64'(rd_data_ff);
   assign idx32        = 32'(res_idx_ff);
   assign cnt32        = 32'(cnt_ff);

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.read_value  = rsp_read_ff;
   assign rsp_ch.found_index = rsp_index_ff;
   assign rsp_ch.count       = rsp_count_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      at_in         = at_ff;
      src_in        = src_ff;
      rem_in        = rem_ff;
      pend_addr_in  = pend_addr_ff;
      pend_vld_in   = 1'b0;
      del_in        = del_ff;
      val_in        = val_ff;
      res_status_in = res_status_ff;
      res_read_in   = res_read_ff;
      res_idx_in    = res_idx_ff;
      rd_addr       = src_ff[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = pend_addr_ff[AW-1:0];
      wr_data       = rd_data_ff;
      rsp_load      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            // get reads here so the data is ready in the next cycle
            rd_addr = pos32[AW-1:0];
            if (accept) begin
               val_in        = req_val64[DATA_WIDTH-1:0];
               at_in         = plan_at;
               res_status_in = plan.status;
               res_read_in   = '0;
               res_idx_in    = '0;
               del_in        = (plan.act == ACT_FIND_DEL);
               case (plan.act)
                  ACT_CLEAR: begin
                     cnt_in   = '0;
                     state_in = S_RESP;
                  end
                  ACT_GET: begin
                     state_in = S_GET;
                  end
                  ACT_FIND_LOC, ACT_FIND_DEL: begin
                     src_in   = '0;
                     state_in = S_FIND;
                  end
                  ACT_OPEN: begin
                     src_in   = cnt_ff - 1'b1;
                     rem_in   = cnt_ff - plan_at;
                     state_in = S_OPEN;
                  end
                  ACT_CLOSE: begin
                     src_in   = plan_at + 1'b1;
                     rem_in   = cnt_ff - plan_at - 1'b1;
                     state_in = S_CLOSE;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_GET: begin
            res_read_in = rd64[31:0];
            state_in    = S_RESP;
         end
         S_FIND: begin
            // src is the next index to read, pend_addr the index of rd_data
            if (pend_vld_ff && (rd_data_ff == val_ff)) begin
               res_idx_in = pend_addr_ff;
               if (del_ff) begin
                  at_in    = pend_addr_ff;
                  src_in   = pend_addr_ff + 1'b1;
                  rem_in   = cnt_ff - pend_addr_ff - 1'b1;
                  state_in = S_CLOSE;
               end else begin
                  state_in = S_RESP;
               end
            end else if (src_ff < cnt_ff) begin
               pend_vld_in  = 1'b1;
               pend_addr_in = src_ff;
               src_in       = src_ff + 1'b1;
            end else if (!pend_vld_ff) begin
               res_status_in = ST_NOTFOUND;
               state_in      = S_RESP;
            end
         end
         S_OPEN: begin
            // walk down: read k-1, write it to k in the next cycle
            if (pend_vld_ff) wr_en = 1'b1;
            if (rem_ff != '0) begin
               pend_vld_in  = 1'b1;
               pend_addr_in = src_ff + 1'b1;
               src_in       = src_ff - 1'b1;
               rem_in       = rem_ff - 1'b1;
            end else if (!pend_vld_ff) begin
               wr_en    = 1'b1;
               wr_addr  = at_ff[AW-1:0];
               wr_data  = val_ff;
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_RESP;
            end
         end
         S_CLOSE: begin
            // walk up: read k+1, write it to k in the next cycle
            if (pend_vld_ff) wr_en = 1'b1;
            if (rem_ff != '0) begin
               pend_vld_in  = 1'b1;
               pend_addr_in = src_ff - 1'b1;
               src_in       = src_ff + 1'b1;
               rem_in       = rem_ff - 1'b1;
            end else if (!pend_vld_ff) begin
               cnt_in   = cnt_ff - 1'b1;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         capacity_ff  <= CAP_RESET;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) capacity_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      at_ff         <= at_in;
      src_ff        <= src_in;
      rem_ff        <= rem_in;
      pend_addr_ff  <= pend_addr_in;
      del_ff        <= del_in;
      val_ff        <= val_in;
      res_status_ff <= res_status_in;
      res_read_ff   <= res_read_in;
      res_idx_ff    <= res_idx_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_read_ff   <= res_read_ff;
         rsp_index_ff  <= idx32[5:0];
         rsp_count_ff  <= cnt32[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("entry count beyond store depth");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("accepted item did not start the sequencer");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP))
      else $error("result loaded outside the response step");

   a_open_not_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OPEN) |-> (cnt_ff < CW'(DEPTH)))
      else $error("insert walk started on a full store");

   a_close_not_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLOSE) |-> (cnt_ff != '0))
      else $error("delete walk started on an empty list");

endmodule
